// ===== sv/ovde_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ovde_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int OP_W       = 3;
    localparam int ST_W       = 2;

    localparam logic [OP_W-1:0] OP_INSERT    = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_FRNT = 3'd1;
    localparam logic [OP_W-1:0] OP_PUSH_BACK = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_FRNT  = 3'd3;
    localparam logic [OP_W-1:0] OP_POP_BACK  = 3'd4;

    localparam logic [ST_W-1:0] STAT_DONE    = 2'd0;
    localparam logic [ST_W-1:0] STAT_FULL    = 2'd1;
    localparam logic [ST_W-1:0] STAT_NOTHING = 2'd2;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_SHIFT_DOWN
    } cell_op_t;

    typedef enum logic [1:0] {
        INS_ORDERED,
        INS_FRONT,
        INS_BACK
    } ins_kind_t;

    typedef enum logic {
        ST_IDLE,
        ST_POP
    } ctrl_state_t;

    typedef struct packed {
        cell_op_t               op;
        ins_kind_t              kind;
        logic                   descending;
        logic [DATA_WIDTH-1:0]  key;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== sv/ovde_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface ovde_in_if;
    logic                            valid;
    logic                            ready;
    logic [ovde_pkg::OP_W-1:0]       operation;
    logic [31:0]                     key_value;
    logic [ovde_pkg::CNT_W-1:0]      pop_count;

    modport source (output valid, output operation, output key_value, output pop_count,
                    input ready);
    modport sink   (input valid, input operation, input key_value, input pop_count,
                    output ready);
endinterface

`default_nettype wire

// ===== sv/ovde_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface ovde_out_if;
    logic                            valid;
    logic                            ready;
    logic [31:0]                     popped_value;
    logic [ovde_pkg::ST_W-1:0]       status;
    logic [ovde_pkg::CNT_W-1:0]      fill_count;
    logic                            last;

    modport source (output valid, output popped_value, output status, output fill_count,
                    output last, input ready);
    modport sink   (input valid, input popped_value, input status, input fill_count,
                    input last, output ready);
endinterface

`default_nettype wire

// ===== sv/ordered_vector_deque_engine_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Ordered vector deque engine: a row of DEPTH key cells with a small controller.
// in_ch  : request items (operation, key_value, pop_count), valid/ready.
// out_ch : result items (popped_value, status, fill_count, last), valid/ready.
// cfg_we / cfg_wdata : writes the descending bit; write only while idle.
// Insert and push: an ordered insert compares every cell's key with the new
// one, push front and push back put the key first or last, and the row shifts
// up in parallel. The result is in the output register the cycle after the
// item is accepted; the next item can be taken then if the receiver takes it.
// A pop of n entries gives min(n, fill count) results via the pop state, one
// per cycle while the receiver takes them; pop front shifts the whole row down
// one cell per result. No new item is accepted while a pop still gives results.
// A pop that removes nothing and an insert or push into a full store give one
// result. Undefined operation codes are accepted and dropped. A stalled receiver
// holds the output register; the block then accepts no item and pops pause.
// Reset empties the store, clears the output valid flag and sets ascending order.
module ordered_vector_deque_engine_top
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    ovde_in_if.sink         in_ch,
    ovde_out_if.source      out_ch,
    input  wire logic       cfg_we,
    input  wire logic       cfg_wdata
);
    import ovde_pkg::*;

    ctrl_state_t            state_reg, state_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [CNT_W-1:0]       remain_reg, remain_next;
    logic                   pop_back_reg, pop_back_next;
    logic                   descending_reg;

    logic                   out_valid_reg;
    logic [31:0]            out_value_reg;
    logic [ST_W-1:0]        out_status_reg;
    logic [CNT_W-1:0]       out_fill_reg;
    logic                   out_last_reg;

    logic                   load;
    logic [31:0]            load_value;
    logic [ST_W-1:0]        load_status;
    logic [CNT_W-1:0]       load_fill;
    logic                   load_last;

    logic                   out_free;
    logic                   accept;
    logic                   is_pop;
    logic [CNT_W-1:0]       pop_n;
    logic [CNT_W-1:0]       count_m1;

    cell_ctrl_t             cell_ctrl;
    logic [DATA_WIDTH-1:0]  cell_data [DEPTH];
    logic [DEPTH:0]         chain;
    logic [DATA_WIDTH-1:0]  back_data;

    assign out_free = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = (state_reg == ST_IDLE) && out_free;
    assign accept = in_ch.valid && in_ch.ready;
    assign is_pop = (in_ch.operation == OP_POP_FRNT) || (in_ch.operation == OP_POP_BACK);
    assign pop_n = (in_ch.pop_count < count_reg) ? in_ch.pop_count : count_reg;
    assign count_m1 = count_reg - 1'b1;
    assign back_data = cell_data[count_m1[IDX_W-1:0]];

    // cell row
    assign chain[0] = 1'b1;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic [DATA_WIDTH-1:0] below;
            logic [DATA_WIDTH-1:0] above;
            logic                  occ;

            assign occ = CNT_W'(gi) < count_reg;

            if (gi == 0)
            begin : g_first
                assign below = cell_ctrl.key;
            end
            else
            begin : g_mid
                assign below = cell_data[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_top
                assign above = '0;
            end
            else
            begin : g_nxt
                assign above = cell_data[gi+1];
            end

            ovde_cell u_cell
            (
                .clk             (clk),
                .ctrl            (cell_ctrl),
                .occupied        (occ),
                .prev_all_before (chain[gi]),
                .below_data      (below),
                .above_data      (above),
                .all_before      (chain[gi+1]),
                .data            (cell_data[gi])
            );
        end
    endgenerate

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && is_pop && (pop_n != '0))
                    state_next = ST_POP;
            end
            ST_POP:
            begin
                if (out_free && (remain_reg == CNT_W'(1)))
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cell_ctrl.op         = CELL_HOLD;
        cell_ctrl.kind       = INS_ORDERED;
        cell_ctrl.descending = descending_reg;
        cell_ctrl.key        = in_ch.key_value[DATA_WIDTH-1:0];
        count_next           = count_reg;
        remain_next          = remain_reg;
        pop_back_next        = pop_back_reg;
        load                 = 1'b0;
        load_value           = '0;
        load_status          = STAT_DONE;
        load_fill            = count_reg;
        load_last            = 1'b1;

        priority if (in_ch.operation == OP_PUSH_FRNT)
            cell_ctrl.kind = INS_FRONT;
        else if (in_ch.operation == OP_PUSH_BACK)
            cell_ctrl.kind = INS_BACK;
        else
            cell_ctrl.kind = INS_ORDERED;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    priority if (in_ch.operation <= OP_PUSH_BACK)
                    begin
                        load = 1'b1;
                        if (count_reg == CNT_W'(DEPTH))
                        begin
                            load_status = STAT_FULL;
                        end
                        else
                        begin
                            cell_ctrl.op = CELL_INSERT;
                            count_next   = count_reg + 1'b1;
                            load_fill    = count_reg + 1'b1;
                        end
                    end
                    else if (is_pop)
                    begin
                        if (pop_n == '0)
                        begin
                            load        = 1'b1;
                            load_status = STAT_NOTHING;
                        end
                        else
                        begin
                            remain_next   = pop_n;
                            pop_back_next = (in_ch.operation == OP_POP_BACK);
                        end
                    end
                    else
                    begin
                        load = 1'b0;
                    end
                end
            end
            ST_POP:
            begin
                if (out_free)
                begin
                    load        = 1'b1;
                    load_value  = 32'(pop_back_reg ? back_data : cell_data[0]);
                    load_fill   = count_m1;
                    load_last   = (remain_reg == CNT_W'(1));
                    count_next  = count_m1;
                    remain_next = remain_reg - 1'b1;
                    if (!pop_back_reg)
                        cell_ctrl.op = CELL_SHIFT_DOWN;
                end
            end
            default: load = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            remain_reg     <= '0;
            pop_back_reg   <= 1'b0;
            descending_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            remain_reg   <= remain_next;
            pop_back_reg <= pop_back_next;
            if (cfg_we)
                descending_reg <= cfg_wdata;
            if (load)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_value_reg  <= load_value;
            out_status_reg <= load_status;
            out_fill_reg   <= load_fill;
            out_last_reg   <= load_last;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.popped_value = out_value_reg;
    assign out_ch.status       = out_status_reg;
    assign out_ch.fill_count   = out_fill_reg;
    assign out_ch.last         = out_last_reg;

endmodule

`default_nettype wire

// ===== sv/ovde_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ovde_cell
(
    input  wire logic                             clk,
    input  wire ovde_pkg::cell_ctrl_t             ctrl,
    input  wire logic                             occupied,
    input  wire logic                             prev_all_before,
    input  wire logic [ovde_pkg::DATA_WIDTH-1:0]  below_data,
    input  wire logic [ovde_pkg::DATA_WIDTH-1:0]  above_data,
    output      logic                             all_before,
    output      logic [ovde_pkg::DATA_WIDTH-1:0]  data
);
    import ovde_pkg::*;

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;
    logic                  cmp_before;
    logic                  is_before;

    assign cmp_before = ctrl.descending ? (data_reg > ctrl.key) : (data_reg < ctrl.key);

    always_comb
    begin
        is_before = 1'b0;
        unique case (ctrl.kind)
            INS_ORDERED: is_before = occupied && cmp_before;
            INS_BACK:    is_before = occupied;
            INS_FRONT:   is_before = 1'b0;
            default:     is_before = 1'b0;
        endcase
    end

    assign all_before = prev_all_before && is_before;

    always_comb
    begin
        data_next = data_reg;
        unique case (ctrl.op)
            CELL_HOLD:       data_next = data_reg;
            CELL_INSERT:
            begin
                if (!prev_all_before)
                    data_next = below_data;
                else if (!is_before)
                    data_next = ctrl.key;
            end
            CELL_SHIFT_DOWN: data_next = above_data;
            default:         data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

`default_nettype wire
